// File: rtl/core/iptl_pkg.sv
// ----------------------------------------------------------------------------
// iptl_pkg
// Shared types, codes and helpers for the IPv6 prefix table with
// longest prefix match.
// ----------------------------------------------------------------------------
package iptl_pkg;

   localparam int ADDR_W   = 128;
   localparam int HALF_W   = 64;
   localparam int LEN_W    = 8;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;
   localparam int VAL_W    = 32;

   localparam logic [LEN_W-1:0] MAX_LEN = 8'h80;

   localparam int ENTRIES_DEF = 64;
   localparam int DATA_W_DEF  = 32;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT  = 3'd0,
      OP_ERASE   = 3'd1,
      OP_EXACT   = 3'd2,
      OP_LONGEST = 3'd3,
      OP_CLEAR   = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_SCAN,
      S_WIPE,
      S_FIN
   } state_type;

   // compare result for one table entry against the held key
   typedef struct packed {
      logic exact;
      logic covers;
   } match_type;

   function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
      return (len > MAX_LEN) ? MAX_LEN : len;
   endfunction

   // ones in the top len bits; len of 128 or more gives all ones
   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      return ~({ADDR_W{1'b1}} >> len);
   endfunction

endpackage

// File: rtl/core/ipv6_prefix_table_lpm.sv
// Insert, erase, exact lookup and longest match scan the whole table, one
// entry per cycle through the single read port, and move to the response
// state once the last entry is folded in. Clear sweeps the table; an
// unknown op goes straight to the response state. One word is in work at
// a time; a finished response may wait in the output register while the
// next word is accepted. After reset each entry is wiped; req_ready is low.
// ----------------------------------------------------------------------------
// ipv6_prefix_table_lpm
// Bounded table of 128-bit prefixes with data words: insert, erase, exact
// lookup, longest prefix match and clear, served by a sequential scan.
// ----------------------------------------------------------------------------
module ipv6_prefix_table_lpm #(
   parameter int ENTRIES = iptl_pkg::ENTRIES_DEF,
   parameter int DATA_W  = iptl_pkg::DATA_W_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [iptl_pkg::OP_W-1:0]     req_operation,
   input  logic [iptl_pkg::HALF_W-1:0]   req_key_hi,
   input  logic [iptl_pkg::HALF_W-1:0]   req_key_lo,
   input  logic [iptl_pkg::LEN_W-1:0]    req_key_len,
   input  logic [iptl_pkg::VAL_W-1:0]    req_value_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [iptl_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_added,
   output logic [iptl_pkg::HALF_W-1:0]   rsp_match_hi,
   output logic [iptl_pkg::HALF_W-1:0]   rsp_match_lo,
   output logic [iptl_pkg::LEN_W-1:0]    rsp_match_len,
   output logic [iptl_pkg::VAL_W-1:0]    rsp_value_out
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [CW-1:0] CNT_END  = CW'(ENTRIES);
   localparam logic [CW-1:0] CNT_LAST = CW'(ENTRIES - 1);

   typedef struct packed {
      logic                        vld;
      logic [iptl_pkg::HALF_W-1:0] hi;
      logic [iptl_pkg::HALF_W-1:0] lo;
      logic [iptl_pkg::LEN_W-1:0]  len;
      logic [DATA_W-1:0]           val;
   } ent_type;

   ent_type mem [ENTRIES];

   iptl_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;

   logic [iptl_pkg::OP_W-1:0]   op_ff, op_in;
   logic [iptl_pkg::HALF_W-1:0] key_hi_ff, key_hi_in;
   logic [iptl_pkg::HALF_W-1:0] key_lo_ff, key_lo_in;
   logic [iptl_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [DATA_W-1:0]           val_ff, val_in;

   ent_type         rd_ff;
   logic            rd_vld_ff, rd_vld_in;
   logic [AW-1:0]   rd_idx_ff;
   logic            issue;

   logic                        hit_ff, hit_in;
   logic [AW-1:0]               hit_idx_ff, hit_idx_in;
   logic [iptl_pkg::HALF_W-1:0] hit_hi_ff, hit_hi_in;
   logic [iptl_pkg::HALF_W-1:0] hit_lo_ff, hit_lo_in;
   logic [iptl_pkg::LEN_W-1:0]  hit_len_ff, hit_len_in;
   logic [DATA_W-1:0]           hit_val_ff, hit_val_in;
   logic                        free_ff, free_in;
   logic [AW-1:0]               free_idx_ff, free_idx_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [iptl_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                          rsp_added_ff, rsp_added_in;
   logic [iptl_pkg::HALF_W-1:0]   rsp_hi_ff, rsp_hi_in;
   logic [iptl_pkg::HALF_W-1:0]   rsp_lo_ff, rsp_lo_in;
   logic [iptl_pkg::LEN_W-1:0]    rsp_len_ff, rsp_len_in;
   logic [iptl_pkg::VAL_W-1:0]    rsp_val_ff, rsp_val_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   ent_type       mem_wdata;

   logic [iptl_pkg::LEN_W-1:0]        req_len_sat;
   logic [iptl_pkg::ADDR_W-1:0]       req_mask;
   logic [iptl_pkg::VAL_W+63:0]       val_pad;
   logic [DATA_W+iptl_pkg::VAL_W-1:0] out_ext;
   logic [DATA_W-1:0]                 out_val;
   logic                              take;
   iptl_pkg::match_type               cmp;

   iptl_match u_match (
      .key_hi  (key_hi_ff),
      .key_lo  (key_lo_ff),
      .key_len (len_ff),
      .ent_vld (rd_ff.vld),
      .ent_hi  (rd_ff.hi),
      .ent_lo  (rd_ff.lo),
      .ent_len (rd_ff.len),
      .result  (cmp)
   );

   assign req_len_sat = iptl_pkg::sat_len(req_key_len);
   assign req_mask    = iptl_pkg::prefix_mask(req_len_sat);
   assign val_pad     = {64'b0, req_value_in};
   assign out_ext     = {{iptl_pkg::VAL_W{1'b0}}, out_val};

   // which scanned entry replaces the current pick
   always_comb begin
      if (op_ff == iptl_pkg::OP_LONGEST) begin
         take = cmp.covers && (!hit_ff || (rd_ff.len > hit_len_ff));
      end else begin
         take = cmp.exact && !hit_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      op_in         = op_ff;
      key_hi_in     = key_hi_ff;
      key_lo_in     = key_lo_ff;
      len_in        = len_ff;
      val_in        = val_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_hi_in     = hit_hi_ff;
      hit_lo_in     = hit_lo_ff;
      hit_len_in    = hit_len_ff;
      hit_val_in    = hit_val_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_added_in  = rsp_added_ff;
      rsp_hi_in     = rsp_hi_ff;
      rsp_lo_in     = rsp_lo_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_val_in    = rsp_val_ff;
      mem_we        = 1'b0;
      mem_waddr     = cnt_ff[AW-1:0];
      mem_wdata     = '0;
      req_ready     = 1'b0;
      issue         = 1'b0;
      out_val       = hit_val_ff;

      // fold in the entry read last cycle
      if (rd_vld_ff) begin
         if (take) begin
            hit_in     = 1'b1;
            hit_idx_in = rd_idx_ff;
            hit_hi_in  = rd_ff.hi;
            hit_lo_in  = rd_ff.lo;
            hit_len_in = rd_ff.len;
            hit_val_in = rd_ff.val;
         end
         if (!rd_ff.vld && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = rd_idx_ff;
         end
      end

      unique case (state_ff)
         iptl_pkg::S_INIT, iptl_pkg::S_WIPE: begin
            mem_we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               cnt_in   = '0;
               state_in = (state_ff == iptl_pkg::S_INIT) ? iptl_pkg::S_IDLE
                                                          : iptl_pkg::S_FIN;
            end
         end
         iptl_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = req_operation;
               key_hi_in = req_key_hi & req_mask[iptl_pkg::ADDR_W-1:iptl_pkg::HALF_W];
               key_lo_in = req_key_lo & req_mask[iptl_pkg::HALF_W-1:0];
               len_in    = req_len_sat;
               val_in    = val_pad[DATA_W-1:0];
               hit_in    = 1'b0;
               free_in   = 1'b0;
               cnt_in    = '0;
               priority if (req_operation == iptl_pkg::OP_INSERT ||
                            req_operation == iptl_pkg::OP_ERASE ||
                            req_operation == iptl_pkg::OP_EXACT ||
                            req_operation == iptl_pkg::OP_LONGEST) begin
                  state_in = iptl_pkg::S_SCAN;
               end else if (req_operation == iptl_pkg::OP_CLEAR) begin
                  state_in = iptl_pkg::S_WIPE;
               end else begin
                  state_in = iptl_pkg::S_FIN;
               end
            end
         end
         iptl_pkg::S_SCAN: begin
            priority if (cnt_ff != CNT_END) begin
               issue  = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end else if (!rd_vld_ff) begin
               state_in = iptl_pkg::S_FIN;
            end else begin
               // last entry still being folded in
            end
         end
         iptl_pkg::S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in      = iptl_pkg::S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = iptl_pkg::ST_NOT_FOUND;
               rsp_added_in  = 1'b0;
               rsp_hi_in     = '0;
               rsp_lo_in     = '0;
               rsp_len_in    = '0;
               rsp_val_in    = '0;
               mem_wdata.hi  = key_hi_ff;
               mem_wdata.lo  = key_lo_ff;
               mem_wdata.len = len_ff;
               priority if (op_ff == iptl_pkg::OP_INSERT) begin
                  if (hit_ff || free_ff) begin
                     mem_we        = 1'b1;
                     mem_waddr     = hit_ff ? hit_idx_ff : free_idx_ff;
                     mem_wdata.vld = 1'b1;
                     mem_wdata.val = val_ff;
                     out_val       = val_ff;
                     rsp_status_in = iptl_pkg::ST_OK;
                     rsp_added_in  = !hit_ff;
                     rsp_hi_in     = key_hi_ff;
                     rsp_lo_in     = key_lo_ff;
                     rsp_len_in    = len_ff;
                     rsp_val_in    = out_ext[iptl_pkg::VAL_W-1:0];
                  end else begin
                     rsp_status_in = iptl_pkg::ST_FULL;
                  end
               end else if (op_ff == iptl_pkg::OP_CLEAR) begin
                  rsp_status_in = iptl_pkg::ST_OK;
               end else if ((op_ff == iptl_pkg::OP_ERASE ||
                             op_ff == iptl_pkg::OP_EXACT ||
                             op_ff == iptl_pkg::OP_LONGEST) && hit_ff) begin
                  // erase frees the slot; the word written back is marked empty
                  mem_we        = (op_ff == iptl_pkg::OP_ERASE);
                  mem_waddr     = hit_idx_ff;
                  rsp_status_in = iptl_pkg::ST_OK;
                  rsp_hi_in     = hit_hi_ff;
                  rsp_lo_in     = hit_lo_ff;
                  rsp_len_in    = hit_len_ff;
                  rsp_val_in    = out_ext[iptl_pkg::VAL_W-1:0];
               end else begin
                  // miss or unused op: not found, fields zero
               end
            end
         end
         default: begin
            state_in = iptl_pkg::S_INIT;
            cnt_in   = '0;
         end
      endcase
   end

   assign rd_vld_in = issue;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (issue) begin
         rd_ff <= mem[cnt_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iptl_pkg::S_INIT;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_hi_ff     <= key_hi_in;
      key_lo_ff     <= key_lo_in;
      len_ff        <= len_in;
      val_ff        <= val_in;
      rd_idx_ff     <= cnt_ff[AW-1:0];
      hit_idx_ff    <= hit_idx_in;
      hit_hi_ff     <= hit_hi_in;
      hit_lo_ff     <= hit_lo_in;
      hit_len_ff    <= hit_len_in;
      hit_val_ff    <= hit_val_in;
      free_idx_ff   <= free_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_added_ff  <= rsp_added_in;
      rsp_hi_ff     <= rsp_hi_in;
      rsp_lo_ff     <= rsp_lo_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_val_ff    <= rsp_val_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_added     = rsp_added_ff;
   assign rsp_match_hi  = rsp_hi_ff;
   assign rsp_match_lo  = rsp_lo_ff;
   assign rsp_match_len = rsp_len_ff;
   assign rsp_value_out = rsp_val_ff;

endmodule

// File: rtl/core/iptl_match.sv
// ----------------------------------------------------------------------------
// iptl_match
// Compare unit shared by every scan: checks one table entry against the
// held key for an exact hit and for prefix coverage.
// ----------------------------------------------------------------------------
module iptl_match (
   input  logic [iptl_pkg::HALF_W-1:0] key_hi,
   input  logic [iptl_pkg::HALF_W-1:0] key_lo,
   input  logic [iptl_pkg::LEN_W-1:0]  key_len,
   input  logic                        ent_vld,
   input  logic [iptl_pkg::HALF_W-1:0] ent_hi,
   input  logic [iptl_pkg::HALF_W-1:0] ent_lo,
   input  logic [iptl_pkg::LEN_W-1:0]  ent_len,
   output iptl_pkg::match_type         result
);

   logic [iptl_pkg::ADDR_W-1:0] diff;
   logic [iptl_pkg::ADDR_W-1:0] mask;

   assign diff = {key_hi, key_lo} ^ {ent_hi, ent_lo};
   assign mask = iptl_pkg::prefix_mask(ent_len);

   always_comb begin
      result.exact  = ent_vld && (ent_len == key_len) && (diff == '0);
      result.covers = ent_vld && (ent_len <= key_len) && ((diff & mask) == '0);
   end

endmodule
